// ----- hw/rtl/iirtdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirtdf_pkg
// Types and constants shared by the transposed direct form II biquad files.
// ----------------------------------------------------------------------------
package iirtdf_pkg;

  typedef logic signed [15:0] sample_t;   // Q1.15
  typedef logic signed [17:0] coef_t;     // Q4.14
  typedef logic signed [39:0] state_t;    // Q10.30
  typedef logic        [2:0]  cfg_idx_t;

  // register indexes on the configuration channel
  localparam cfg_idx_t REG_FEED_ZERO    = 3'd0;
  localparam cfg_idx_t REG_FEED_ONE     = 3'd1;
  localparam cfg_idx_t REG_FEED_TWO     = 3'd2;
  localparam cfg_idx_t REG_BACK_ONE     = 3'd3;
  localparam cfg_idx_t REG_BACK_TWO     = 3'd4;
  localparam cfg_idx_t REG_OUTPUT_SCALE = 3'd5;

  // coefficient values after reset
  localparam coef_t RST_FEED_ZERO    = 18'sd8192;
  localparam coef_t RST_FEED_ONE     = 18'sd4096;
  localparam coef_t RST_FEED_TWO     = 18'sd1638;
  localparam coef_t RST_BACK_ONE     = 18'sd8192;
  localparam coef_t RST_BACK_TWO     = 18'sd4915;
  localparam coef_t RST_OUTPUT_SCALE = 18'sd16384;

  localparam state_t STATE_MAX = {1'b0, {39{1'b1}}};
  localparam state_t STATE_MIN = {1'b1, {39{1'b0}}};
  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage

// ----- hw/rtl/iirtdf_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirtdf channel interfaces
// Valid/ready channels for samples in, results out and coefficient writes.
// ----------------------------------------------------------------------------
interface iirtdf_in_if;
  logic                valid;
  logic                ready;
  iirtdf_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirtdf_out_if;
  logic                valid;
  logic                ready;
  iirtdf_pkg::sample_t sample_out;
  logic                clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iirtdf_cfg_if;
  logic                 valid;
  logic                 ready;
  iirtdf_pkg::cfg_idx_t index;
  iirtdf_pkg::coef_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/iir_transposed_df2_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_transposed_df2_filter_top
// Second-order IIR, transposed direct form II, one shared 18x25 multiplier
// with accumulate, stepped by a small sequencer.
// ----------------------------------------------------------------------------
// the result is registered in the output step, after the b0 step and the
//   low and high scale steps; the next sample can be taken on the last update
//   step; the eight (six with ORDER 1) sequencer steps run seven (five)
//   products one per cycle through the single multiplier plus one output step
// a result stalled at the output holds the sequencer in its output step
// reset (rst_n low, synchronous): coefficients to defaults, delay terms zero
// ----------------------------------------------------------------------------
module iir_transposed_df2_filter_top #(
  parameter int ORDER = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  iirtdf_in_if.sink           in_ch,
  iirtdf_out_if.source        out_ch,
  iirtdf_cfg_if.sink          cfg_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_SLO,
    ST_SHI,
    ST_OUT,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2
  } state_t;

  state_t state_r, state_nxt;

  iirtdf_pkg::coef_t  feed_zero_r, feed_one_r, feed_two_r;
  iirtdf_pkg::coef_t  back_one_r, back_two_r, output_scale_r;
  iirtdf_pkg::coef_t  feed_zero_nxt, feed_one_nxt, feed_two_nxt;
  iirtdf_pkg::coef_t  back_one_nxt, back_two_nxt, output_scale_nxt;
  iirtdf_pkg::state_t s0_r, s1_r, s0_nxt, s1_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath registers
  iirtdf_pkg::sample_t x_r, x_nxt;
  iirtdf_pkg::sample_t y_r, y_nxt;
  iirtdf_pkg::sample_t out_sample_r, out_sample_nxt;
  logic                out_clip_r, out_clip_nxt;
  logic signed [40:0]  acc_r, acc_nxt;     // b0*x + s0, exact
  logic signed [58:0]  wide_r, wide_nxt;   // scale * acc, Q.44
  logic signed [41:0]  upd_r, upd_nxt;     // delay term update sum

  // shared multiplier
  iirtdf_pkg::coef_t   mul_a;
  logic signed [24:0]  mul_b;
  logic signed [42:0]  prod;
  logic signed [43:0]  prod_x2;

  logic signed [59:0]  rnd;
  logic signed [30:0]  r_q15;
  logic                r_clip;
  logic signed [41:0]  upd_diff;
  iirtdf_pkg::state_t  upd_sat;
  logic                last_step;
  logic                out_free;

  assign prod    = mul_a * mul_b;
  assign prod_x2 = {prod, 1'b0};

  // rounding to Q.15, ties toward plus infinity
  assign rnd    = {wide_r[58], wide_r} + (60'sd1 <<< 28);
  assign r_q15  = rnd[59:29];
  assign r_clip = !((&r_q15[30:15]) || !(|r_q15[30:15]));

  // delay term subtract and saturate to 40 bits
  assign upd_diff = upd_r - prod_x2[41:0];
  always_comb begin
    if (upd_diff[41:39] == 3'b000 || upd_diff[41:39] == 3'b111) begin
      upd_sat = upd_diff[39:0];
    end else if (upd_diff[41]) begin
      upd_sat = iirtdf_pkg::STATE_MIN;
    end else begin
      upd_sat = iirtdf_pkg::STATE_MAX;
    end
  end

  assign last_step = (state_r == ST_A2) || (ORDER < 2 && state_r == ST_A1);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == ST_IDLE) || last_step;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clip_r;
  assign cfg_ch.ready      = 1'b1;

  always_comb begin
    state_nxt        = state_r;
    feed_zero_nxt    = feed_zero_r;
    feed_one_nxt     = feed_one_r;
    feed_two_nxt     = feed_two_r;
    back_one_nxt     = back_one_r;
    back_two_nxt     = back_two_r;
    output_scale_nxt = output_scale_r;
    s0_nxt           = s0_r;
    s1_nxt           = s1_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    x_nxt            = x_r;
    y_nxt            = y_r;
    out_sample_nxt   = out_sample_r;
    out_clip_nxt     = out_clip_r;
    acc_nxt          = acc_r;
    wide_nxt         = wide_r;
    upd_nxt          = upd_r;
    mul_a            = feed_zero_r;
    mul_b            = 25'(x_r);

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        iirtdf_pkg::REG_FEED_ZERO:    feed_zero_nxt    = cfg_ch.data;
        iirtdf_pkg::REG_FEED_ONE:     feed_one_nxt     = cfg_ch.data;
        iirtdf_pkg::REG_FEED_TWO:     feed_two_nxt     = cfg_ch.data;
        iirtdf_pkg::REG_BACK_ONE:     back_one_nxt     = cfg_ch.data;
        iirtdf_pkg::REG_BACK_TWO:     back_two_nxt     = cfg_ch.data;
        iirtdf_pkg::REG_OUTPUT_SCALE: output_scale_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      ST_B0: begin
        mul_a     = feed_zero_r;
        mul_b     = 25'(x_r);
        acc_nxt   = {s0_r[39], s0_r} + prod_x2[40:0];
        state_nxt = ST_SLO;
      end
      ST_SLO: begin
        // low 24 bits of acc as an unsigned partial
        mul_a     = output_scale_r;
        mul_b     = {1'b0, acc_r[23:0]};
        wide_nxt  = 59'(prod);
        state_nxt = ST_SHI;
      end
      ST_SHI: begin
        // high part of acc carries the sign
        mul_a     = output_scale_r;
        mul_b     = {{8{acc_r[40]}}, acc_r[40:24]};
        wide_nxt  = wide_r + {prod[34:0], 24'b0};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          if (r_clip) begin
            y_nxt = r_q15[30] ? iirtdf_pkg::SAMPLE_MIN : iirtdf_pkg::SAMPLE_MAX;
          end else begin
            y_nxt = r_q15[15:0];
          end
          out_sample_nxt = y_nxt;
          out_clip_nxt   = r_clip;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_B1;
        end
      end
      ST_B1: begin
        mul_a = feed_one_r;
        mul_b = 25'(x_r);
        if (ORDER >= 2) begin
          upd_nxt = {{2{s1_r[39]}}, s1_r} + prod_x2[41:0];
        end else begin
          upd_nxt = prod_x2[41:0];
        end
        state_nxt = ST_A1;
      end
      ST_A1: begin
        mul_a     = back_one_r;
        mul_b     = 25'(y_r);
        s0_nxt    = upd_sat;
        state_nxt = (ORDER >= 2) ? ST_B2 : ST_IDLE;
      end
      ST_B2: begin
        mul_a     = feed_two_r;
        mul_b     = 25'(x_r);
        upd_nxt   = prod_x2[41:0];
        state_nxt = ST_A2;
      end
      ST_A2: begin
        mul_a     = back_two_r;
        mul_b     = 25'(y_r);
        s1_nxt    = upd_sat;
        state_nxt = ST_IDLE;
      end
      default: ;
    endcase

    // next sample may enter in idle or on the last update step
    if (in_ch.valid && in_ch.ready) begin
      x_nxt     = in_ch.sample_in;
      state_nxt = ST_B0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      feed_zero_r    <= iirtdf_pkg::RST_FEED_ZERO;
      feed_one_r     <= iirtdf_pkg::RST_FEED_ONE;
      feed_two_r     <= iirtdf_pkg::RST_FEED_TWO;
      back_one_r     <= iirtdf_pkg::RST_BACK_ONE;
      back_two_r     <= iirtdf_pkg::RST_BACK_TWO;
      output_scale_r <= iirtdf_pkg::RST_OUTPUT_SCALE;
      s0_r           <= '0;
      s1_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      feed_zero_r    <= feed_zero_nxt;
      feed_one_r     <= feed_one_nxt;
      feed_two_r     <= feed_two_nxt;
      back_one_r     <= back_one_nxt;
      back_two_r     <= back_two_nxt;
      output_scale_r <= output_scale_nxt;
      s0_r           <= s0_nxt;
      s1_r           <= s1_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
    acc_r        <= acc_nxt;
    wide_r       <= wide_nxt;
    upd_r        <= upd_nxt;
  end

endmodule

// ----- hw/rtl/iirtdf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirtdf_checker
// Port-level checks on the biquad: beat ordering and result bookkeeping.
// ----------------------------------------------------------------------------
module iirtdf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input iirtdf_pkg::sample_t out_sample,
  input logic                out_clipped
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // samples taken whose result beat has not gone out yet
  always_comb begin
    pend_nxt = pend_r;
    if (in_beat && !out_beat) begin
      pend_nxt = pend_r + 3'd1;
    end else if (!in_beat && out_beat) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("input taken again right after a beat");

  a_no_phantom_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result shown with no sample pending");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more than two samples in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
    else $error("stalled result changed");

endmodule

bind iir_transposed_df2_filter_top iirtdf_checker u_iirtdf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sample  (out_ch.sample_out),
  .out_clipped (out_ch.clipped)
);

// ----- verif/iir_transposed_df2_filter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_transposed_df2_filter_top_test
// Self-checking bench for the transposed direct form II biquad. A short
// table of directed beats (coefficient extremes, pass-through, saturation,
// writes to unused indexes) is followed by random phases, each with its own
// coefficient set. A bit-true fixed-point model of the filter predicts every
// output beat; both channels see random stall bursts except in the last phase.
// ----------------------------------------------------------------------------
module iir_transposed_df2_filter_top_test;

  localparam int FILTER_ORDER   = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 113;

  // indexes past the last register, writes there must be dropped
  localparam iirtdf_pkg::cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam iirtdf_pkg::cfg_idx_t REG_SPARE_HI = 3'd7;

  localparam iirtdf_pkg::coef_t COEF_MAX  = 18'sh1ffff;
  localparam iirtdf_pkg::coef_t COEF_MIN  = 18'sh20000;
  localparam iirtdf_pkg::coef_t COEF_ZERO = 18'sd0;
  localparam iirtdf_pkg::coef_t COEF_UNIT = 18'sd16384;

  localparam longint ROUND_HALF = longint'(1) << 28;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum int {SET_DEFAULT, SET_WILD, SET_GENTLE, SET_EXTREME} setting_kind_t;

  typedef struct packed {
    iirtdf_pkg::sample_t sample_out;
    logic                clipped;
  } out_beat_t;

  typedef struct {
    row_kind_t            kind;
    iirtdf_pkg::cfg_idx_t idx;
    iirtdf_pkg::coef_t    data;
    iirtdf_pkg::sample_t  x;
    bit                   known;
    out_beat_t            res;
  } dir_row_t;

  typedef struct {
    bit        known;
    out_beat_t res;
  } known_t;

  typedef iirtdf_pkg::coef_t coef_set_t [0:5];

  logic clk;
  logic rst_n;

  iirtdf_in_if  in_ch ();
  iirtdf_out_if out_ch ();
  iirtdf_cfg_if cfg_ch ();

  iir_transposed_df2_filter_top #(
    .ORDER (FILTER_ORDER)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // filter model state
  iirtdf_pkg::coef_t coefs [0:5];
  longint            delay0;
  longint            delay1;

  out_beat_t pending_q [$];
  known_t    known_q [$];
  dir_row_t  directed [$];

  int  mismatches;
  int  samples_sent;
  int  directed_samples;
  int  results_seen;
  int  clips_seen;
  int  coef_writes;
  int  settings_run;
  int  quiet_cycles;
  bit  idling_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic longint clamp_state(longint v);
    if (v > longint'(iirtdf_pkg::STATE_MAX)) return longint'(iirtdf_pkg::STATE_MAX);
    if (v < longint'(iirtdf_pkg::STATE_MIN)) return longint'(iirtdf_pkg::STATE_MIN);
    return v;
  endfunction

  function automatic void reset_filter_model();
    coefs[iirtdf_pkg::REG_FEED_ZERO]    = iirtdf_pkg::RST_FEED_ZERO;
    coefs[iirtdf_pkg::REG_FEED_ONE]     = iirtdf_pkg::RST_FEED_ONE;
    coefs[iirtdf_pkg::REG_FEED_TWO]     = iirtdf_pkg::RST_FEED_TWO;
    coefs[iirtdf_pkg::REG_BACK_ONE]     = iirtdf_pkg::RST_BACK_ONE;
    coefs[iirtdf_pkg::REG_BACK_TWO]     = iirtdf_pkg::RST_BACK_TWO;
    coefs[iirtdf_pkg::REG_OUTPUT_SCALE] = iirtdf_pkg::RST_OUTPUT_SCALE;
    delay0 = 0;
    delay1 = 0;
  endfunction

  function automatic void write_coef(iirtdf_pkg::cfg_idx_t idx, iirtdf_pkg::coef_t data);
    if (idx <= iirtdf_pkg::REG_OUTPUT_SCALE) coefs[idx] = data;
  endfunction

  function automatic out_beat_t filter_step(iirtdf_pkg::sample_t x);
    longint    xs, b0, b1, b2, a1, a2, sc;
    longint    acc, wide, r, y, next0;
    out_beat_t res;
    xs = x;
    b0 = coefs[iirtdf_pkg::REG_FEED_ZERO];
    b1 = coefs[iirtdf_pkg::REG_FEED_ONE];
    b2 = coefs[iirtdf_pkg::REG_FEED_TWO];
    a1 = coefs[iirtdf_pkg::REG_BACK_ONE];
    a2 = coefs[iirtdf_pkg::REG_BACK_TWO];
    sc = coefs[iirtdf_pkg::REG_OUTPUT_SCALE];
    // Q.30 sum times Q4.14 scale gives Q.44, round half up to Q.15
    acc  = b0 * xs * 2 + delay0;
    wide = sc * acc;
    r    = (wide + ROUND_HALF) >>> 29;
    y    = r;
    res.clipped = 1'b0;
    if (r > longint'(iirtdf_pkg::SAMPLE_MAX)) begin
      y = iirtdf_pkg::SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (r < longint'(iirtdf_pkg::SAMPLE_MIN)) begin
      y = iirtdf_pkg::SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample_out = iirtdf_pkg::sample_t'(y);
    // feedback taps use the saturated output
    if (FILTER_ORDER >= 2) begin
      next0  = clamp_state(delay1 + b1 * xs * 2 - a1 * y * 2);
      delay1 = clamp_state(b2 * xs * 2 - a2 * y * 2);
      delay0 = next0;
    end else begin
      delay0 = clamp_state(b1 * xs * 2 - a1 * y * 2);
      delay1 = 0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic iirtdf_pkg::coef_t rand_coef();
    return iirtdf_pkg::coef_t'($urandom);
  endfunction

  function automatic iirtdf_pkg::coef_t rand_coef_span(int span);
    return iirtdf_pkg::coef_t'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  function automatic iirtdf_pkg::coef_t rand_extreme();
    return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
  endfunction

  function automatic iirtdf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return iirtdf_pkg::SAMPLE_MAX;
          1: return iirtdf_pkg::SAMPLE_MIN;
          2: return iirtdf_pkg::sample_t'(0);
          3: return iirtdf_pkg::sample_t'(1);
          default: return iirtdf_pkg::sample_t'(-1);
        endcase
      end
      1, 2: return iirtdf_pkg::sample_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return iirtdf_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_set_t make_setting(setting_kind_t kind);
    coef_set_t s;
    case (kind)
      SET_DEFAULT: begin
        s[iirtdf_pkg::REG_FEED_ZERO]    = iirtdf_pkg::RST_FEED_ZERO;
        s[iirtdf_pkg::REG_FEED_ONE]     = iirtdf_pkg::RST_FEED_ONE;
        s[iirtdf_pkg::REG_FEED_TWO]     = iirtdf_pkg::RST_FEED_TWO;
        s[iirtdf_pkg::REG_BACK_ONE]     = iirtdf_pkg::RST_BACK_ONE;
        s[iirtdf_pkg::REG_BACK_TWO]     = iirtdf_pkg::RST_BACK_TWO;
        s[iirtdf_pkg::REG_OUTPUT_SCALE] = iirtdf_pkg::RST_OUTPUT_SCALE;
      end
      SET_WILD: begin
        s[iirtdf_pkg::REG_FEED_ZERO]    = rand_coef();
        s[iirtdf_pkg::REG_FEED_ONE]     = rand_coef();
        s[iirtdf_pkg::REG_FEED_TWO]     = rand_coef();
        s[iirtdf_pkg::REG_BACK_ONE]     = rand_coef();
        s[iirtdf_pkg::REG_BACK_TWO]     = rand_coef();
        s[iirtdf_pkg::REG_OUTPUT_SCALE] = rand_coef();
      end
      SET_GENTLE: begin
        // small feedback keeps the poles well inside the unit circle
        s[iirtdf_pkg::REG_FEED_ZERO]    = rand_coef_span(8192);
        s[iirtdf_pkg::REG_FEED_ONE]     = rand_coef_span(8192);
        s[iirtdf_pkg::REG_FEED_TWO]     = rand_coef_span(8192);
        s[iirtdf_pkg::REG_BACK_ONE]     = rand_coef_span(8192);
        s[iirtdf_pkg::REG_BACK_TWO]     = rand_coef_span(4096);
        s[iirtdf_pkg::REG_OUTPUT_SCALE] = rand_coef_span(16384);
      end
      default: begin
        s[iirtdf_pkg::REG_FEED_ZERO]    = rand_extreme();
        s[iirtdf_pkg::REG_FEED_ONE]     = rand_extreme();
        s[iirtdf_pkg::REG_FEED_TWO]     = rand_extreme();
        s[iirtdf_pkg::REG_BACK_ONE]     = rand_extreme();
        s[iirtdf_pkg::REG_BACK_TWO]     = rand_extreme();
        s[iirtdf_pkg::REG_OUTPUT_SCALE] = rand_extreme();
      end
    endcase
    return s;
  endfunction

  function automatic void add_write(iirtdf_pkg::cfg_idx_t idx, iirtdf_pkg::coef_t data);
    dir_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.data  = data;
    row.x     = '0;
    row.known = 1'b0;
    row.res   = '0;
    directed.push_back(row);
  endfunction

  function automatic void add_sample(iirtdf_pkg::sample_t x, bit known,
                                     iirtdf_pkg::sample_t y, logic clip);
    dir_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = iirtdf_pkg::REG_FEED_ZERO;
    row.data  = COEF_ZERO;
    row.x     = x;
    row.known = known;
    row.res.sample_out = y;
    row.res.clipped    = clip;
    directed.push_back(row);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] error: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- channel drivers

  task automatic send_sample(iirtdf_pkg::sample_t x);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic in_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // the sequencer keeps updating delay terms after the output beat
  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_coef(iirtdf_pkg::cfg_idx_t idx, iirtdf_pkg::coef_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    write_coef(idx, data);
    coef_writes++;
  endtask

  task automatic cfg_quiet();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_filter(coef_set_t s);
    in_quiet();
    wait_idle();
    if ($urandom_range(0, 3) == 0)
      send_coef(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, rand_coef());
    send_coef(iirtdf_pkg::REG_FEED_ZERO,    s[iirtdf_pkg::REG_FEED_ZERO]);
    send_coef(iirtdf_pkg::REG_FEED_ONE,     s[iirtdf_pkg::REG_FEED_ONE]);
    send_coef(iirtdf_pkg::REG_FEED_TWO,     s[iirtdf_pkg::REG_FEED_TWO]);
    send_coef(iirtdf_pkg::REG_BACK_ONE,     s[iirtdf_pkg::REG_BACK_ONE]);
    send_coef(iirtdf_pkg::REG_BACK_TWO,     s[iirtdf_pkg::REG_BACK_TWO]);
    send_coef(iirtdf_pkg::REG_OUTPUT_SCALE, s[iirtdf_pkg::REG_OUTPUT_SCALE]);
    cfg_quiet();
    settings_run++;
  endtask

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 15) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    out_beat_t got;
    known_t    k;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        results_seen++;
        got.sample_out = out_ch.sample_out;
        got.clipped    = out_ch.clipped;
        if (got.clipped) clips_seen++;
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("output beat %0d/%0b with nothing expected",
                                    got.sample_out, got.clipped));
        end else begin
          want = pending_q.pop_front();
          if (got.sample_out !== want.sample_out)
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      results_seen, got.sample_out, want.sample_out));
          if (got.clipped !== want.clipped)
            report_mismatch($sformatf("result %0d: clipped %0b, expected %0b",
                                      results_seen, got.clipped, want.clipped));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        want = filter_step(in_ch.sample_in);
        if (known_q.size() != 0) begin
          k = known_q.pop_front();
          if (k.known) want = k.res;
        end
        pending_q.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) moved = 1'b1;
    end
    if (!rst_n || moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat on any channel for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_sequence
    coef_set_t     setting;
    setting_kind_t kind;
    known_t        k;
    bit            cfg_open;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = iirtdf_pkg::REG_FEED_ZERO;
    cfg_ch.data      = COEF_ZERO;
    mismatches       = 0;
    samples_sent     = 0;
    directed_samples = 0;
    results_seen     = 0;
    clips_seen       = 0;
    coef_writes      = 0;
    settings_run     = 0;
    quiet_cycles     = 0;
    idling_on        = 1'b1;
    cfg_open         = 1'b0;
    reset_filter_model();

    // default coefficients: y = x / 2 from a clean state
    add_sample(iirtdf_pkg::sample_t'(0), 1'b1, iirtdf_pkg::sample_t'(0), 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MAX, 1'b1, iirtdf_pkg::sample_t'(16384), 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(1), 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(-1), 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(12345), 1'b0, '0, 1'b0);
    // pass-through, two zero beats flush the delay line
    add_write(iirtdf_pkg::REG_FEED_ZERO, COEF_UNIT);
    add_write(iirtdf_pkg::REG_FEED_ONE, COEF_ZERO);
    add_write(iirtdf_pkg::REG_FEED_TWO, COEF_ZERO);
    add_write(iirtdf_pkg::REG_BACK_ONE, COEF_ZERO);
    add_write(iirtdf_pkg::REG_BACK_TWO, COEF_ZERO);
    add_write(iirtdf_pkg::REG_OUTPUT_SCALE, COEF_UNIT);
    add_sample(iirtdf_pkg::sample_t'(0), 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(0), 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MAX, 1'b1, iirtdf_pkg::SAMPLE_MAX, 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MIN, 1'b1, iirtdf_pkg::SAMPLE_MIN, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(0), 1'b1, iirtdf_pkg::sample_t'(0), 1'b0);
    // largest gain saturates full-scale input
    add_write(iirtdf_pkg::REG_OUTPUT_SCALE, COEF_MAX);
    add_sample(iirtdf_pkg::SAMPLE_MAX, 1'b1, iirtdf_pkg::SAMPLE_MAX, 1'b1);
    add_sample(iirtdf_pkg::SAMPLE_MIN, 1'b1, iirtdf_pkg::SAMPLE_MIN, 1'b1);
    add_sample(iirtdf_pkg::sample_t'(1), 1'b0, '0, 1'b0);
    // unused indexes must leave every coefficient alone
    add_write(REG_SPARE_LO, COEF_MIN);
    add_write(REG_SPARE_HI, COEF_MAX);
    add_sample(iirtdf_pkg::sample_t'(1), 1'b0, '0, 1'b0);
    // all coefficients at the negative limit, then the positive one
    add_write(iirtdf_pkg::REG_FEED_ZERO, COEF_MIN);
    add_write(iirtdf_pkg::REG_FEED_ONE, COEF_MIN);
    add_write(iirtdf_pkg::REG_FEED_TWO, COEF_MIN);
    add_write(iirtdf_pkg::REG_BACK_ONE, COEF_MIN);
    add_write(iirtdf_pkg::REG_BACK_TWO, COEF_MIN);
    add_write(iirtdf_pkg::REG_OUTPUT_SCALE, COEF_MIN);
    add_sample(iirtdf_pkg::SAMPLE_MAX, 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(0), 1'b0, '0, 1'b0);
    add_write(iirtdf_pkg::REG_FEED_ZERO, COEF_MAX);
    add_write(iirtdf_pkg::REG_FEED_ONE, COEF_MAX);
    add_write(iirtdf_pkg::REG_FEED_TWO, COEF_MAX);
    add_write(iirtdf_pkg::REG_BACK_ONE, COEF_MAX);
    add_write(iirtdf_pkg::REG_BACK_TWO, COEF_MAX);
    add_write(iirtdf_pkg::REG_OUTPUT_SCALE, COEF_MAX);
    add_sample(iirtdf_pkg::SAMPLE_MAX, 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
    add_sample(iirtdf_pkg::sample_t'(12345), 1'b0, '0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        if (!cfg_open) begin
          in_quiet();
          wait_idle();
          cfg_open = 1'b1;
          settings_run++;
        end
        send_coef(directed[i].idx, directed[i].data);
      end else begin
        if (cfg_open) begin
          cfg_quiet();
          cfg_open = 1'b0;
        end
        k.known = directed[i].known;
        k.res   = directed[i].res;
        known_q.push_back(k);
        send_sample(directed[i].x);
        directed_samples++;
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) kind = SET_DEFAULT;
      else if (p == 1) kind = SET_EXTREME;
      else if (p == RANDOM_PHASES - 1) kind = SET_GENTLE;
      else kind = setting_kind_t'($urandom_range(SET_WILD, SET_EXTREME));
      // final phase runs at full rate on both sides
      if (p == RANDOM_PHASES - 1) idling_on = 1'b0;
      setting = make_setting(kind);
      program_filter(setting);
      repeat (PHASE_SAMPLES) send_sample(pick_sample());
    end

    in_quiet();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

    $display("run: %0d samples (%0d directed) over %0d coefficient sets, %0d register writes",
             samples_sent, directed_samples, settings_run, coef_writes);
    $display("run: %0d results checked, %0d saturated", results_seen, clips_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
